// ===== src/pps_pkg.sv =====
// ----------------------------------------------------------------------------
// pps_pkg
// Shared widths, codes and types for the preemptive priority scheduler.
// ----------------------------------------------------------------------------
package pps_pkg;

    localparam int NUM_SLOTS    = 16;
    localparam int SLOT_W       = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int SLOT_FIELD_W = 4;
    localparam int SLOT_EXT_W   = (SLOT_W > SLOT_FIELD_W) ? SLOT_W : SLOT_FIELD_W;
    localparam int TICK_W       = 16;
    localparam int PRIO_W       = 8;

    localparam int IN_TDATA_W   = 48;
    localparam int IN_TUSER_W   = 1;
    localparam int OUT_TDATA_W  = 40;
    localparam int OUT_TUSER_W  = 3;

    typedef logic [TICK_W-1:0] tick_t;
    typedef logic [PRIO_W-1:0] prio_t;
    typedef logic [SLOT_W-1:0] slot_idx_t;

    localparam tick_t CLOCK_MAX = {TICK_W{1'b1}};

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_TICK = 1'b1;

endpackage

// ===== src/preemptive_priority_scheduler.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// Task slot table with a lowest-priority-first pick per scheduling tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_*: s_tuser selects load (write one task slot) or
//   tick (run one scheduling step). One result word leaves on m_* for every
//   input word.
//   A load goes from accept straight to the done state, which puts its
//   result word into the output register. A tick passes the states scan,
//   compare, read, update and done: a sequencer walks the slot
//   table one entry per cycle through a single compare unit on the table's
//   read port, then reads and decrements the picked task's remaining time.
//   s_tready is high only while no word is in progress. One result waits in
//   the output register; a stalled receiver holds it and the next word is
//   accepted and worked on, finishing when the output register frees.
//   Reset clears the clock, all pending marks and the output valid; table
//   contents are undefined until a slot is loaded.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler
    import pps_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // slot[3:0], arrival[19:4], burst[35:20], prio[43:36], zero[47:44]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // mode[0]
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // ran_slot[3:0], finish_tick[19:4], now[35:20], zero[39:36]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    // ran_valid[0], finished[1], all_done[2]
    output logic [OUT_TUSER_W-1:0] m_tuser
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_RD   = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    tick_t arrival_mem   [NUM_SLOTS];
    tick_t remaining_mem [NUM_SLOTS];
    prio_t priority_mem  [NUM_SLOTS];

    logic [2:0]           state_reg;
    logic [NUM_SLOTS-1:0] pend_reg;
    tick_t                clock_reg;
    slot_idx_t            idx_reg;

    logic                 rd_vld_reg;
    logic                 rd_pend_reg;
    tick_t                rd_arr_reg;
    prio_t                rd_prio_reg;
    slot_idx_t            rd_idx_reg;

    logic                 have_reg;
    slot_idx_t            best_idx_reg;
    tick_t                best_arr_reg;
    prio_t                best_prio_reg;
    tick_t                rem_rd_reg;

    logic                 res_ran_reg;
    logic [SLOT_FIELD_W-1:0] res_slot_reg;
    logic                 res_fin_reg;
    tick_t                res_fin_tick_reg;

    logic                 m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TUSER_W-1:0] m_tuser_reg;

    logic [SLOT_FIELD_W-1:0] in_slot;
    tick_t                in_arrival;
    tick_t                in_burst;
    prio_t                in_prio;
    logic [SLOT_EXT_W-1:0] in_slot_ext;
    slot_idx_t            in_idx;
    logic                 in_range;
    logic                 accept;
    logic                 load_wr;
    logic                 cand_ok;
    logic                 better;
    logic                 out_free;
    tick_t                clock_next;
    tick_t                rem_dec;

    assign in_slot     = s_tdata[3:0];
    assign in_arrival  = s_tdata[19:4];
    assign in_burst    = s_tdata[35:20];
    assign in_prio     = s_tdata[43:36];
    assign in_slot_ext = SLOT_EXT_W'(in_slot);
    assign in_idx      = in_slot_ext[SLOT_W-1:0];
    assign in_range    = 32'(in_slot) < NUM_SLOTS;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign load_wr  = accept && (s_tuser[0] == MODE_LOAD) && in_range;

    assign cand_ok = rd_vld_reg && rd_pend_reg && (rd_arr_reg <= clock_reg);
    assign better  = !have_reg || (rd_prio_reg < best_prio_reg) ||
                     ((rd_prio_reg == best_prio_reg) && (rd_arr_reg < best_arr_reg));

    assign out_free   = !m_tvalid_reg || m_tready;
    assign clock_next = (clock_reg != CLOCK_MAX) ? clock_reg + 1'b1 : clock_reg;
    assign rem_dec    = rem_rd_reg - 1'b1;

    // table storage: one write port, registered reads
    always_ff @(posedge clk)
    begin
        if (load_wr)
        begin
            arrival_mem[in_idx]   <= in_arrival;
            priority_mem[in_idx]  <= in_prio;
            remaining_mem[in_idx] <= in_burst;
        end
        else if ((state_reg == ST_UPD) && have_reg)
        begin
            remaining_mem[best_idx_reg] <= rem_dec;
        end
        rd_arr_reg  <= arrival_mem[idx_reg];
        rd_prio_reg <= priority_mem[idx_reg];
        rem_rd_reg  <= remaining_mem[best_idx_reg];
    end

    // scan datapath and result payload
    always_ff @(posedge clk)
    begin
        rd_pend_reg <= pend_reg[idx_reg];
        rd_idx_reg  <= idx_reg;
        if (cand_ok && better)
        begin
            best_idx_reg  <= rd_idx_reg;
            best_arr_reg  <= rd_arr_reg;
            best_prio_reg <= rd_prio_reg;
        end
        if (accept && (s_tuser[0] == MODE_LOAD))
        begin
            res_ran_reg      <= 1'b0;
            res_slot_reg     <= '0;
            res_fin_reg      <= 1'b0;
            res_fin_tick_reg <= '0;
        end
        else if (state_reg == ST_UPD)
        begin
            res_ran_reg      <= have_reg;
            res_slot_reg     <= have_reg ? SLOT_FIELD_W'(best_idx_reg) : '0;
            res_fin_reg      <= have_reg && (rem_dec == '0);
            res_fin_tick_reg <= (have_reg && (rem_dec == '0)) ? clock_next : '0;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            m_tdata_reg <= {4'b0000, clock_reg, res_fin_tick_reg, res_slot_reg};
            m_tuser_reg <= {~|pend_reg, res_fin_reg, res_ran_reg};
        end
    end

    // sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            clock_reg    <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            have_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= (state_reg == ST_SCAN);
            if (cand_ok)
            begin
                have_reg <= 1'b1;
            end
            if ((state_reg == ST_DONE) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (s_tuser[0] == MODE_LOAD)
                        begin
                            if (in_range)
                            begin
                                pend_reg[in_idx] <= (in_burst != '0);
                            end
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            have_reg  <= 1'b0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (idx_reg == SLOT_W'(NUM_SLOTS - 1))
                    begin
                        state_reg <= ST_CMP;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_CMP:
                begin
                    state_reg <= ST_RD;
                end
                ST_RD:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    clock_reg <= clock_next;
                    if (have_reg && (rem_dec == '0))
                    begin
                        pend_reg[best_idx_reg] <= 1'b0;
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
